// ===== rtl/pclm_pkg.sv =====
// ----------------------------------------------------------------------------
// pclm_pkg: page cache list manager shared types
// Page count, link encoding, list classes, request codes and sequencer states.
// ----------------------------------------------------------------------------
package pclm_pkg;
	localparam int NUM_PAGES = 16;
	localparam int PW = $clog2(NUM_PAGES);
	localparam int LW = PW + 1;
	localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

	typedef logic [LW-1:0] link_t;
	typedef logic [PW-1:0] page_t;

	typedef enum logic [1:0] {CLS_FREE = 2'd0, CLS_READ = 2'd1, CLS_WRITE = 2'd2} cls_t;
	typedef enum logic [1:0] {
		REQ_CLAIM = 2'd0, REQ_DROP = 2'd1, REQ_LOOKUP = 2'd2, REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_UNLINK, ST_PUT, ST_SCAN, ST_SCAN_CHK, ST_OUT
	} state_t;

	typedef struct packed {
		logic granted;
		logic [3:0] page_out;
		logic flush_needed;
	} result_t;
endpackage

// ===== rtl/pclm_if.sv =====
// ----------------------------------------------------------------------------
// pclm_stream_if: valid/ready channel
// Carries one beat of payload of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface pclm_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pclm_ram.sv =====
// ----------------------------------------------------------------------------
// pclm_ram: generic single write, single read RAM
// Registered read port.
// ----------------------------------------------------------------------------
module pclm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/page_cache_list_manager_unit.sv =====
// ----------------------------------------------------------------------------
// page_cache_list_manager_unit: LRU page cache list manager
// Free, read and write page lists with claim, drop and tag lookup.
// ----------------------------------------------------------------------------
// One request at a time. A claim or drop passes through the decode, unlink, put
// and output states before its result is presented. A lookup walks the read list
// one page at a time through the registered-read tag RAM, checking at most NUM_PAGES pages.
// The result is held in an output register until taken, and no new request is
// accepted until then.
module page_cache_list_manager_unit (
	input logic clk,
	input logic arst_n,
	pclm_stream_if.sink   req,
	pclm_stream_if.source rsp
);
	localparam int PW = pclm_pkg::PW;
	localparam int LW = pclm_pkg::LW;

	pclm_pkg::state_t state_q, state_d;
	pclm_pkg::link_t prev_q [pclm_pkg::NUM_PAGES];
	pclm_pkg::link_t next_q [pclm_pkg::NUM_PAGES];
	logic [1:0] cls_q [pclm_pkg::NUM_PAGES];
	logic lu_q [pclm_pkg::NUM_PAGES];
	pclm_pkg::link_t head_q [3];
	pclm_pkg::link_t tail_q [3];

	logic [1:0] rq_q;
	logic wr_q, luin_q;
	logic [3:0] sel_q;
	logic [31:0] tag_q;
	pclm_pkg::link_t p_q;
	logic [1:0] src_q;
	logic hit_q, flush_q, grant_q;
	logic [PW:0] guard_q;
	pclm_pkg::result_t res_q;
	logic rvalid_q;

	logic key_we;
	logic [31:0] key_rd;
	pclm_pkg::page_t key_ra;

	pclm_ram #(.WIDTH(32), .DEPTH(pclm_pkg::NUM_PAGES)) u_key (
		.clk(clk), .we(key_we), .waddr(p_q[PW-1:0]), .wdata(tag_q),
		.raddr(key_ra), .rdata(key_rd)
	);

	assign key_ra = p_q[PW-1:0];
	assign key_we = (state_q == pclm_pkg::ST_PUT) && (rq_q == pclm_pkg::REQ_CLAIM)
		&& grant_q;
	assign req.ready = (state_q == pclm_pkg::ST_IDLE) && !rvalid_q;
	assign rsp.valid = rvalid_q;
	assign rsp.data = res_q;

	logic sel_ok;
	assign sel_ok = ({1'b0, sel_q} < 5'(pclm_pkg::NUM_PAGES));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pclm_pkg::ST_IDLE:     if (req.valid && req.ready) state_d = pclm_pkg::ST_DECODE;
			pclm_pkg::ST_DECODE:   state_d = (rq_q == pclm_pkg::REQ_LOOKUP) ?
				pclm_pkg::ST_SCAN : pclm_pkg::ST_UNLINK;
			pclm_pkg::ST_UNLINK:   state_d = pclm_pkg::ST_PUT;
			pclm_pkg::ST_PUT:      state_d = pclm_pkg::ST_OUT;
			pclm_pkg::ST_SCAN:     state_d = (p_q == pclm_pkg::NIL ||
				guard_q == (PW+1)'(pclm_pkg::NUM_PAGES)) ? pclm_pkg::ST_OUT :
				pclm_pkg::ST_SCAN_CHK;
			pclm_pkg::ST_SCAN_CHK: state_d = (key_rd == tag_q) ?
				pclm_pkg::ST_UNLINK : pclm_pkg::ST_SCAN;
			pclm_pkg::ST_OUT:      state_d = pclm_pkg::ST_IDLE;
			default:               state_d = pclm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pclm_pkg::ST_IDLE;
			rvalid_q <= 1'b0;
			guard_q <= '0;
			for (int i = 0; i < pclm_pkg::NUM_PAGES; i++) begin
				cls_q[i] <= pclm_pkg::CLS_FREE;
				lu_q[i] <= 1'b0;
				prev_q[i] <= (i == 0) ? pclm_pkg::NIL : LW'(i - 1);
				next_q[i] <= (i == pclm_pkg::NUM_PAGES - 1) ? pclm_pkg::NIL : LW'(i + 1);
			end
			head_q[0] <= '0;
			tail_q[0] <= LW'(pclm_pkg::NUM_PAGES - 1);
			head_q[1] <= pclm_pkg::NIL; tail_q[1] <= pclm_pkg::NIL;
			head_q[2] <= pclm_pkg::NIL; tail_q[2] <= pclm_pkg::NIL;
		end else begin
			state_q <= state_d;
			if (rsp.valid && rsp.ready) rvalid_q <= 1'b0;
			unique case (state_q)
				pclm_pkg::ST_IDLE: if (req.valid && req.ready) begin
					rq_q <= req.data.req_type; wr_q <= req.data.want_write;
					luin_q <= req.data.low_use; sel_q <= req.data.page_sel;
					tag_q <= req.data.page_tag;
					grant_q <= 1'b0; flush_q <= 1'b0; hit_q <= 1'b0;
					guard_q <= '0;
				end
				pclm_pkg::ST_DECODE: begin
					// pick the page: the claim victim, the dropped page or the read-list head for a lookup
					if (rq_q == pclm_pkg::REQ_CLAIM) begin
						if (head_q[0] != pclm_pkg::NIL) begin
							p_q <= head_q[0]; src_q <= pclm_pkg::CLS_FREE; grant_q <= 1'b1;
						end else if (head_q[1] != pclm_pkg::NIL) begin
							p_q <= head_q[1]; src_q <= pclm_pkg::CLS_READ; grant_q <= 1'b1;
						end else if (wr_q && head_q[2] != pclm_pkg::NIL) begin
							p_q <= head_q[2]; src_q <= pclm_pkg::CLS_WRITE;
							grant_q <= 1'b1; flush_q <= 1'b1;
						end
					end else if (rq_q == pclm_pkg::REQ_DROP) begin
						p_q <= LW'(sel_q);
						if (sel_ok && cls_q[sel_q[PW-1:0]] != pclm_pkg::CLS_FREE) begin
							grant_q <= 1'b1;
							src_q <= cls_q[sel_q[PW-1:0]] == pclm_pkg::CLS_READ ?
								pclm_pkg::CLS_READ : pclm_pkg::CLS_WRITE;
						end
					end else begin
						p_q <= head_q[1]; src_q <= pclm_pkg::CLS_READ;
					end
				end
				pclm_pkg::ST_SCAN: guard_q <= guard_q + 1'b1;
				pclm_pkg::ST_SCAN_CHK: if (key_rd == tag_q) begin
					hit_q <= 1'b1;
					grant_q <= (tail_q[1] != p_q);
				end else begin
					p_q <= next_q[p_q[PW-1:0]];
				end
				pclm_pkg::ST_UNLINK: if (grant_q) begin
					if (prev_q[p_q[PW-1:0]] == pclm_pkg::NIL) head_q[src_q] <= next_q[p_q[PW-1:0]];
					else next_q[prev_q[p_q[PW-1:0]][PW-1:0]] <= next_q[p_q[PW-1:0]];
					if (next_q[p_q[PW-1:0]] == pclm_pkg::NIL) tail_q[src_q] <= prev_q[p_q[PW-1:0]];
					else prev_q[next_q[p_q[PW-1:0]][PW-1:0]] <= prev_q[p_q[PW-1:0]];
				end
				pclm_pkg::ST_PUT: if (grant_q) begin
					// append at tail, or at head for a low-use read claim
					if (rq_q == pclm_pkg::REQ_CLAIM && !wr_q && luin_q) begin
						lu_q[p_q[PW-1:0]] <= 1'b1;
						cls_q[p_q[PW-1:0]] <= pclm_pkg::CLS_READ;
						prev_q[p_q[PW-1:0]] <= pclm_pkg::NIL;
						next_q[p_q[PW-1:0]] <= head_q[1];
						if (head_q[1] == pclm_pkg::NIL) tail_q[1] <= p_q;
						else prev_q[head_q[1][PW-1:0]] <= p_q;
						head_q[1] <= p_q;
					end else begin : tl
						logic [1:0] l;
						l = (rq_q == pclm_pkg::REQ_DROP) ? pclm_pkg::CLS_FREE :
							(rq_q == pclm_pkg::REQ_LOOKUP) ? pclm_pkg::CLS_READ :
							wr_q ? pclm_pkg::CLS_WRITE : pclm_pkg::CLS_READ;
						if (rq_q == pclm_pkg::REQ_CLAIM) lu_q[p_q[PW-1:0]] <= 1'b0;
						cls_q[p_q[PW-1:0]] <= l;
						next_q[p_q[PW-1:0]] <= pclm_pkg::NIL;
						prev_q[p_q[PW-1:0]] <= tail_q[l];
						if (tail_q[l] == pclm_pkg::NIL) head_q[l] <= p_q;
						else next_q[tail_q[l][PW-1:0]] <= p_q;
						tail_q[l] <= p_q;
					end
				end
				pclm_pkg::ST_OUT: begin
					rvalid_q <= 1'b1;
					unique case (rq_q)
						pclm_pkg::REQ_CLAIM: res_q <= '{grant_q, grant_q ? p_q[3:0] : 4'd0, flush_q};
						pclm_pkg::REQ_DROP:  res_q <= '{grant_q, sel_q, 1'b0};
						pclm_pkg::REQ_LOOKUP: res_q <= '{hit_q, hit_q ? p_q[3:0] : 4'd0, 1'b0};
						default: res_q <= '0;
					endcase
				end
				default: ;
			endcase
		end
	end

	a_out_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pclm_pkg::ST_OUT) |=> rvalid_q) else $error("result lost");
	a_idle_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (state_q == pclm_pkg::ST_IDLE)) else $error("ready while busy");
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(rvalid_q && res_q.flush_needed) |-> res_q.granted) else $error("flush w/o grant");
	a_guard: assert property (@(posedge clk) disable iff (!arst_n)
		guard_q <= (PW+1)'(pclm_pkg::NUM_PAGES)) else $error("scan overrun");
endmodule

// ===== tb/sv/page_cache_list_manager_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_cache_list_manager_unit_test: self-checking bench for the page list unit
// Drives claim, drop, lookup and unused-code beats with random gaps and stalls. A
// cycle-free model of the free, read and write lists predicts each result,
// and every response beat is checked field by field in order.
// ----------------------------------------------------------------------------
module page_cache_list_manager_unit_test;
	typedef struct packed {
		pclm_pkg::req_t req_type;
		logic want_write;
		logic low_use;
		logic [3:0] page_sel;
		logic [31:0] page_tag;
	} page_req_t;

	localparam int STALL_LIMIT = 4000;
	localparam int NP = pclm_pkg::NUM_PAGES;

	logic clk;
	logic arst_n;

	pclm_stream_if #(.T(page_req_t)) req_ch ();
	pclm_stream_if #(.T(pclm_pkg::result_t)) rsp_ch ();

	page_cache_list_manager_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	pclm_pkg::cls_t page_cls[NP];
	logic page_lu[NP];
	logic [31:0] page_tag_mem[NP];
	int prev_pg[NP];
	int next_pg[NP];
	int head_pg[3];
	int tail_pg[3];

	pclm_pkg::result_t pending_results[$];
	int errors;
	int beats_sent;
	int beats_checked;
	int flushes;
	int idle_cycles = 0;
	bit rsp_no_stall;
	logic [31:0] tag_pool[8];

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH beat %0d %s: got %0h expected %0h", beats_checked, what, got, want);
		errors++;
	endtask

	function automatic void lists_reset();
		for (int i = 0; i < NP; i++) begin
			page_cls[i] = pclm_pkg::CLS_FREE;
			page_lu[i] = 1'b0;
			page_tag_mem[i] = '0;
			prev_pg[i] = (i == 0) ? NP : i - 1;
			next_pg[i] = (i == NP - 1) ? NP : i + 1;
		end
		head_pg[pclm_pkg::CLS_FREE] = 0;
		tail_pg[pclm_pkg::CLS_FREE] = NP - 1;
		head_pg[pclm_pkg::CLS_READ] = NP;
		tail_pg[pclm_pkg::CLS_READ] = NP;
		head_pg[pclm_pkg::CLS_WRITE] = NP;
		tail_pg[pclm_pkg::CLS_WRITE] = NP;
	endfunction

	function automatic void link_tail(input pclm_pkg::cls_t l, input int p);
		int t;
		t = tail_pg[l];
		if (t == NP) begin
			head_pg[l] = p;
			prev_pg[p] = NP;
		end else begin
			next_pg[t] = p;
			prev_pg[p] = t;
		end
		next_pg[p] = NP;
		tail_pg[l] = p;
		page_cls[p] = l;
	endfunction

	function automatic void link_head(input pclm_pkg::cls_t l, input int p);
		int h;
		h = head_pg[l];
		if (h == NP) begin
			tail_pg[l] = p;
			next_pg[p] = NP;
		end else begin
			prev_pg[h] = p;
			next_pg[p] = h;
		end
		prev_pg[p] = NP;
		head_pg[l] = p;
		page_cls[p] = l;
	endfunction

	function automatic void unlink(input pclm_pkg::cls_t l, input int p);
		int pv;
		int nx;
		pv = prev_pg[p];
		nx = next_pg[p];
		if (pv == NP) head_pg[l] = nx; else next_pg[pv] = nx;
		if (nx == NP) tail_pg[l] = pv; else prev_pg[nx] = pv;
		prev_pg[p] = NP;
		next_pg[p] = NP;
	endfunction

	function automatic pclm_pkg::result_t page_list_step(input page_req_t r);
		pclm_pkg::result_t res;
		int p;
		int guard;
		res = '0;
		case (r.req_type)
			pclm_pkg::REQ_CLAIM: begin
				p = NP;
				if (head_pg[pclm_pkg::CLS_FREE] != NP) begin
					p = head_pg[pclm_pkg::CLS_FREE];
					unlink(pclm_pkg::CLS_FREE, p);
				end else if (head_pg[pclm_pkg::CLS_READ] != NP) begin
					p = head_pg[pclm_pkg::CLS_READ];
					unlink(pclm_pkg::CLS_READ, p);
				end else if (r.want_write && head_pg[pclm_pkg::CLS_WRITE] != NP) begin
					p = head_pg[pclm_pkg::CLS_WRITE];
					unlink(pclm_pkg::CLS_WRITE, p);
					res.flush_needed = 1'b1;
				end
				if (p != NP) begin
					page_tag_mem[p] = r.page_tag;
					if (r.want_write) begin
						page_lu[p] = 1'b0;
						link_tail(pclm_pkg::CLS_WRITE, p);
					end else if (r.low_use) begin
						page_lu[p] = 1'b1;
						link_head(pclm_pkg::CLS_READ, p);
					end else begin
						page_lu[p] = 1'b0;
						link_tail(pclm_pkg::CLS_READ, p);
					end
					res.granted = 1'b1;
					res.page_out = p[3:0];
				end
			end
			pclm_pkg::REQ_DROP: begin
				p = int'(r.page_sel);
				res.page_out = r.page_sel;
				if (page_cls[p] != pclm_pkg::CLS_FREE) begin
					unlink(page_cls[p], p);
					link_tail(pclm_pkg::CLS_FREE, p);
					res.granted = 1'b1;
				end
			end
			pclm_pkg::REQ_LOOKUP: begin
				p = head_pg[pclm_pkg::CLS_READ];
				guard = 0;
				while (p < NP && guard < NP) begin
					if (page_tag_mem[p] == r.page_tag) begin
						if (tail_pg[pclm_pkg::CLS_READ] != p) begin
							unlink(pclm_pkg::CLS_READ, p);
							link_tail(pclm_pkg::CLS_READ, p);
						end
						res.granted = 1'b1;
						res.page_out = p[3:0];
						break;
					end
					p = next_pg[p];
					guard++;
				end
			end
			default: res = '0;
		endcase
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_beat(input page_req_t r, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(page_list_step(r));
		beats_sent++;
	endtask

	task automatic send_req(input pclm_pkg::req_t t, input logic wr, input logic lu,
			input logic [3:0] sel, input logic [31:0] tag);
		page_req_t r;
		r.req_type = t;
		r.want_write = wr;
		r.low_use = lu;
		r.page_sel = sel;
		r.page_tag = tag;
		send_beat(r, pick_gap());
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_no_stall) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		pclm_pkg::result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("MISMATCH response beat with nothing outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.data.granted !== want.granted)
					report("granted", 32'(rsp_ch.data.granted), 32'(want.granted));
				if (rsp_ch.data.page_out !== want.page_out)
					report("page_out", 32'(rsp_ch.data.page_out), 32'(want.page_out));
				if (rsp_ch.data.flush_needed !== want.flush_needed)
					report("flush_needed", 32'(rsp_ch.data.flush_needed),
						32'(want.flush_needed));
				if (want.granted && want.flush_needed) flushes++;
				beats_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("page_cache_list_manager_unit_test: errors");
			$finish;
		end
	end

	task automatic test_fill_and_evict();
		// fill every page, then force read eviction and write eviction
		for (int i = 0; i < NP; i++)
			send_req(pclm_pkg::REQ_CLAIM, i[0], i[1], 4'h0,
				(i == 3) ? 32'hFFFF_FFFF : tag_pool[i % 8]);
		send_req(pclm_pkg::REQ_CLAIM, 1'b0, 1'b1, 4'hF, 32'h0000_0000);
		send_req(pclm_pkg::REQ_LOOKUP, 1'b0, 1'b0, 4'h0, tag_pool[0]);
		send_req(pclm_pkg::REQ_LOOKUP, 1'b1, 1'b1, 4'hF, 32'hDEAD_BEEF);
		for (int i = 0; i < 10; i++)
			send_req(pclm_pkg::REQ_CLAIM, 1'b1, 1'b0, 4'h0, tag_pool[i % 8]);
		send_req(pclm_pkg::REQ_CLAIM, 1'b0, 1'b0, 4'h0, 32'h1234_5678);
		send_req(pclm_pkg::REQ_NONE, 1'b1, 1'b1, 4'hF, 32'hFFFF_FFFF);
	endtask

	task automatic test_drops();
		send_req(pclm_pkg::REQ_DROP, 1'b0, 1'b0, 4'h0, 32'h0);
		send_req(pclm_pkg::REQ_DROP, 1'b1, 1'b1, 4'hF, 32'hFFFF_FFFF);
		send_req(pclm_pkg::REQ_DROP, 1'b0, 1'b0, 4'h0, 32'h0);
		send_req(pclm_pkg::REQ_DROP, 1'b0, 1'b0, 4'h5, 32'h0);
	endtask

	task automatic test_random(input int count, input int write_pct);
		page_req_t r;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 40) r.req_type = pclm_pkg::REQ_CLAIM;
			else if (roll < 65) r.req_type = pclm_pkg::REQ_DROP;
			else if (roll < 95) r.req_type = pclm_pkg::REQ_LOOKUP;
			else r.req_type = pclm_pkg::REQ_NONE;
			r.want_write = ($urandom_range(0, 99) < write_pct);
			r.low_use = 1'($urandom_range(0, 1));
			r.page_sel = 4'($urandom_range(0, NP - 1));
			r.page_tag = ($urandom_range(0, 9) < 7) ? tag_pool[$urandom_range(0, 7)] : $urandom;
			rsp_no_stall = (n % 200) < 40;
			send_beat(r, rsp_no_stall ? 0 : pick_gap());
			if (n == count / 2) drain();
		end
	endtask

	initial begin
		errors = 0;
		beats_sent = 0;
		beats_checked = 0;
		flushes = 0;
		rsp_no_stall = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		for (int i = 0; i < 8; i++) tag_pool[i] = $urandom;
		lists_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fill_and_evict();
		test_drops();
		drain();
		test_random(350, 20);
		test_random(350, 70);
		test_random(350, 5);
		drain();
		repeat (80) @(posedge clk);

		$display("sent %0d request beats, checked %0d responses, %0d write-back evictions",
			beats_sent, beats_checked, flushes);
		$display("covered claims with all three eviction sources, drops, lookups, unused code");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("page_cache_list_manager_unit_test: clean");
		end else begin
			$display("page_cache_list_manager_unit_test: errors");
		end
		$finish;
	end
endmodule
